/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequent in the cycle after an antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check a consequent in the same cycle as an antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tme_pkg.sv */
`timescale 1ns / 1ps

package tme_pkg;

    localparam int MODE_W   = 3;
    localparam int AMOUNT_W = 16;
    localparam int IP_W     = 16;
    localparam int BYTE_W   = 8;

    localparam logic [MODE_W-1:0] MODE_ADD       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LEFT      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOP_BEG  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LOOP_END  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_INPUT     = 3'd6;
    localparam logic [MODE_W-1:0] MODE_OUTPUT    = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [AMOUNT_W-1:0] amount;
        logic [IP_W-1:0]     target;
        logic [BYTE_W-1:0]   in_byte;
        logic                in_eof;
    } instr_t;

    typedef struct packed {
        logic [IP_W-1:0]   next_ip;
        logic              jump_taken;
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
    } result_t;

endpackage

/* hw/rtl/tme_ram.sv */
`timescale 1ns / 1ps

module tme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/tme_rem.sv */
`timescale 1ns / 1ps

module tme_rem import tme_pkg::*; #(
    parameter int TAPE_DEPTH = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [AMOUNT_W-1:0]           amount,
    output logic                          done,
    output logic [$clog2(TAPE_DEPTH)-1:0] rem
);

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam int MW = AMOUNT_W + 2;
    localparam int PW = AMOUNT_W + MW;
    localparam int SH = AMOUNT_W + AW;
    localparam logic [63:0]         SCALE   = 64'd1 << SH;
    localparam logic [MW-1:0]       RECIP   = MW'(SCALE / 64'(TAPE_DEPTH) + 64'd1);
    localparam logic [AMOUNT_W:0]   DEPTH_X = (AMOUNT_W + 1)'(TAPE_DEPTH);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [AMOUNT_W-1:0] quo_reg, quo_next;
    logic [AMOUNT_W-1:0] val_reg, val_next;
    logic [AW-1:0]       rem_reg, rem_next;
    logic [PW-1:0]       prod;
    logic [AMOUNT_W:0]   quo_depth;

    // quotient by reciprocal multiplication, then subtract quotient times depth
    always_comb
    begin
        prod      = PW'(amount) * PW'(RECIP);
        quo_depth = {1'b0, quo_reg} * DEPTH_X;
        run_next  = run_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            quo_next = AMOUNT_W'(prod[PW-1:SH]);
            val_next = amount;
        end
        else if (run_reg)
        begin
            rem_next  = AW'(val_reg - quo_depth[AMOUNT_W-1:0]);
            run_next  = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* hw/rtl/tape_machine_instruction_executor_unit.sv */
`timescale 1ns / 1ps
// An accepted instruction is registered and executed in ST_EXEC, which registers the result
// once the output is free; a new one is taken only in ST_IDLE, after the tape RAM read-modify-write.
// Pointer moves first wait in ST_MOD for the remainder unit when TAPE_DEPTH is not a power of two.
// Reset: pointers clear at once; then a clearing pass writes zero to all TAPE_DEPTH cells,
// one per cycle, with instr_ready held low until the pass ends.

module tape_machine_instruction_executor_unit import tme_pkg::*; #(
    parameter int TAPE_DEPTH = 16384,
    parameter int CELL_WIDTH = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    output logic    instr_ready,
    input  instr_t  instr,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam bit IS_POW2 = ((TAPE_DEPTH & (TAPE_DEPTH - 1)) == 0);
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(TAPE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAPE_DEPTH - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MOD   = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]         dp_reg, dp_next;
    logic [IP_W-1:0]       ip_reg, ip_next;
    instr_t                item_reg, item_next;
    result_t               res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    logic                  accept;
    logic                  is_move;
    logic                  mod_start;
    logic                  mod_done;
    logic [AW-1:0]         mod_rem;
    logic                  out_free;
    logic [CELL_WIDTH-1:0] cur_cell;
    logic [CELL_WIDTH-1:0] cell_new;
    logic                  cell_we;
    logic [AW-1:0]         step;
    logic [AW:0]           sum;
    logic [AW:0]           diff;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [CELL_WIDTH-1:0] ram_wdata;

    assign instr_ready = (state_reg == ST_IDLE);
    assign accept      = instr_valid && instr_ready;
    assign is_move     = (instr.mode == MODE_RIGHT) || (instr.mode == MODE_LEFT);
    assign mod_start   = accept && is_move && !IS_POW2;
    assign out_free    = !res_valid_reg || result_ready;

    tme_rem #(
        .TAPE_DEPTH(TAPE_DEPTH)
    ) u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .amount(instr.amount),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    tme_ram #(
        .WIDTH(CELL_WIDTH),
        .DEPTH(TAPE_DEPTH)
    ) u_tape (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(dp_reg),
        .rdata(cur_cell)
    );

    always_comb
    begin
        step      = IS_POW2 ? AW'(item_reg.amount) : mod_rem;
        sum       = {1'b0, dp_reg} + {1'b0, step};
        diff      = {1'b0, dp_reg} - {1'b0, step};
        cell_new  = cur_cell;
        cell_we   = 1'b0;
        dp_next   = dp_reg;
        res_next  = res_reg;
        res_next.next_ip    = ip_reg + 1'b1;
        res_next.jump_taken = 1'b0;
        res_next.out_valid  = 1'b0;
        res_next.out_byte   = '0;
        unique case (item_reg.mode)
            MODE_ADD:
            begin
                cell_new = cur_cell + CELL_WIDTH'(item_reg.amount);
                cell_we  = 1'b1;
            end
            MODE_SUB:
            begin
                cell_new = cur_cell - CELL_WIDTH'(item_reg.amount);
                cell_we  = 1'b1;
            end
            MODE_RIGHT:
            begin
                dp_next = (sum >= DEPTH_X) ? AW'(sum - DEPTH_X) : AW'(sum);
            end
            MODE_LEFT:
            begin
                dp_next = diff[AW] ? AW'(diff + DEPTH_X) : AW'(diff);
            end
            MODE_LOOP_BEG:
            begin
                res_next.jump_taken = (cur_cell == '0);
            end
            MODE_LOOP_END:
            begin
                res_next.jump_taken = (cur_cell != '0);
            end
            MODE_INPUT:
            begin
                cell_new = item_reg.in_eof ? '1 : CELL_WIDTH'(item_reg.in_byte);
                cell_we  = 1'b1;
            end
            MODE_OUTPUT:
            begin
                res_next.out_valid = 1'b1;
                res_next.out_byte  = cur_cell[BYTE_W-1:0];
            end
        endcase
        if (res_next.jump_taken)
        begin
            res_next.next_ip = item_reg.target + 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ip_next        = ip_reg;
        item_next      = item_reg;
        res_valid_next = res_valid_reg && !result_ready;
        ram_we         = 1'b0;
        ram_waddr      = dp_reg;
        ram_wdata      = cell_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = instr;
                    state_next = mod_start ? ST_MOD : ST_EXEC;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    ram_we         = cell_we;
                    ip_next        = res_next.next_ip;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            dp_reg        <= '0;
            ip_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ip_reg        <= ip_next;
            res_valid_reg <= res_valid_next;
            if ((state_reg == ST_EXEC) && out_free)
            begin
                dp_reg <= dp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if ((state_reg == ST_EXEC) && out_free)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

/* hw/rtl/tme_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tme_checker import tme_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    instr_valid,
    input logic    instr_ready,
    input instr_t  instr,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    logic [IP_W-1:0] ip_reg;
    logic [IP_W-1:0] ip_inc;
    logic            in_txn;
    logic            out_txn;

    assign in_txn  = instr_valid && instr_ready;
    assign out_txn = result_valid && result_ready;
    assign ip_inc  = ip_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg <= '0;
        end
        else if (out_txn)
        begin
            ip_reg <= result.next_ip;
        end
    end

    `ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")
    `ASSERT_NEXT(a_one_at_a_time, in_txn, !instr_ready, "accepted a transaction while busy")
    `ASSERT_SAME(a_out_not_jump, result_valid && result.out_valid, !result.jump_taken, "output flagged as jump")
    `ASSERT_SAME(a_ip_advance, result_valid && !result.jump_taken, result.next_ip == ip_inc, "next_ip did not advance by one")

endmodule

bind tape_machine_instruction_executor_unit tme_checker u_tme_checker (.*);

/* tb/tape_machine_instruction_executor_unit_tb.sv */
`timescale 1ns / 1ps

module tape_machine_instruction_executor_unit_tb;
    import tme_pkg::*;

    localparam int TAPE_DEPTH     = 16384;
    localparam int DP_W           = $clog2(TAPE_DEPTH);
    localparam int CELL_W         = 16;
    localparam int RANDOM_ITEMS   = 500;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 4 * (TAPE_DEPTH + 256);
    localparam int MAX_PRINTED    = 50;

    class tape_scoreboard;
        logic [CELL_W-1:0] tape_mem [TAPE_DEPTH];
        logic [DP_W-1:0]   data_ptr;
        logic [IP_W-1:0]   instr_ptr;
        result_t           pending_results[$];
        int                errors;
        int                checked;
        int                mode_count [8];
        int                jumps;
        int                bytes_out;
        int                eof_reads;

        function void clear_machine();
            foreach (tape_mem[i])
                tape_mem[i] = '0;
            data_ptr  = '0;
            instr_ptr = '0;
            errors    = 0;
            checked   = 0;
            jumps     = 0;
            bytes_out = 0;
            eof_reads = 0;
            foreach (mode_count[i])
                mode_count[i] = 0;
        endfunction

        function void execute(instr_t x);
            logic [CELL_W-1:0] cur_cell;
            logic [DP_W-1:0]   step;
            result_t           r;
            cur_cell = tape_mem[data_ptr];
            step = x.amount[DP_W-1:0];
            r = '0;
            r.next_ip = instr_ptr + 1'b1;
            mode_count[x.mode]++;
            case (x.mode)
                MODE_ADD:      tape_mem[data_ptr] = cur_cell + x.amount;
                MODE_SUB:      tape_mem[data_ptr] = cur_cell - x.amount;
                MODE_RIGHT:    data_ptr = data_ptr + step;
                MODE_LEFT:     data_ptr = data_ptr - step;
                MODE_LOOP_BEG: r.jump_taken = (cur_cell == '0);
                MODE_LOOP_END: r.jump_taken = (cur_cell != '0);
                MODE_INPUT:
                begin
                    if (x.in_eof)
                    begin
                        tape_mem[data_ptr] = '1;
                        eof_reads++;
                    end
                    else
                        tape_mem[data_ptr] = CELL_W'(x.in_byte);
                end
                default:
                begin
                    r.out_valid = 1'b1;
                    r.out_byte  = cur_cell[BYTE_W-1:0];
                    bytes_out++;
                end
            endcase
            if (r.jump_taken)
            begin
                r.next_ip = x.target + 1'b1;
                jumps++;
            end
            instr_ptr = r.next_ip;
            pending_results.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %h with no instruction pending", got));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.next_ip !== want.next_ip)
                report($sformatf("result %0d next_ip %h, want %h",
                                 checked, got.next_ip, want.next_ip));
            if (got.jump_taken !== want.jump_taken)
                report($sformatf("result %0d jump_taken %b, want %b",
                                 checked, got.jump_taken, want.jump_taken));
            if (got.out_valid !== want.out_valid)
                report($sformatf("result %0d out_valid %b, want %b",
                                 checked, got.out_valid, want.out_valid));
            if (got.out_byte !== want.out_byte)
                report($sformatf("result %0d out_byte %h, want %h",
                                 checked, got.out_byte, want.out_byte));
        endtask
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    instr_valid;
    logic    instr_ready;
    instr_t  instr;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    tape_scoreboard sb;
    int idle_cycles;
    int burst_left;
    int stall_style;
    int style_left;

    tape_machine_instruction_executor_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .instr        (instr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (instr_valid && instr_ready)
                sb.execute(instr);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if ((instr_valid && instr_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("tape_machine_instruction_executor_unit_tb NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left  = (stall_style == 3) ? $urandom_range(4, 24) : $urandom_range(16, 96);
        end
        else
            style_left = style_left - 1;
        case (stall_style)
            0:       result_ready <= 1'b1;
            1:       result_ready <= 1'($urandom_range(0, 1));
            2:       result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= 1'b0;
        endcase
    end

    function automatic logic [AMOUNT_W-1:0] rand_word();
        return AMOUNT_W'($urandom);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic instr_t make_instr(logic [MODE_W-1:0] mode, logic [AMOUNT_W-1:0] amount,
                                          logic [IP_W-1:0] target, logic [BYTE_W-1:0] in_byte,
                                          logic in_eof);
        instr_t x;
        x.mode    = mode;
        x.amount  = amount;
        x.target  = target;
        x.in_byte = in_byte;
        x.in_eof  = in_eof;
        return x;
    endfunction

    function automatic instr_t random_instr();
        instr_t x;
        int     pick;
        int     sel;
        x    = make_instr('0, rand_word(), rand_word(), rand_byte(), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        if (pick < 18)
            x.mode = MODE_ADD;
        else if (pick < 35)
            x.mode = MODE_SUB;
        else if (pick < 45)
            x.mode = MODE_RIGHT;
        else if (pick < 55)
            x.mode = MODE_LEFT;
        else if (pick < 67)
            x.mode = MODE_LOOP_BEG;
        else if (pick < 79)
            x.mode = MODE_LOOP_END;
        else if (pick < 88)
            x.mode = MODE_INPUT;
        else
            x.mode = MODE_OUTPUT;
        if (x.mode == MODE_ADD || x.mode == MODE_SUB)
        begin
            if (sel < 6)
                x.amount = AMOUNT_W'($urandom_range(0, 3));
            else if (sel < 9)
                x.amount = AMOUNT_W'($urandom_range(0, 300));
        end
        else if (x.mode == MODE_RIGHT || x.mode == MODE_LEFT)
        begin
            if (sel < 7)
                x.amount = AMOUNT_W'($urandom_range(0, 3));
            else if (sel < 9)
                x.amount = AMOUNT_W'($urandom_range(TAPE_DEPTH - 3, TAPE_DEPTH + 3));
        end
        else if (x.mode == MODE_INPUT)
        begin
            if ($urandom_range(0, 7) == 0)
                x.in_byte = '0;
            x.in_eof = ($urandom_range(0, 5) == 0);
        end
        return x;
    endfunction

    // enter and leave at a falling edge
    task send(instr_t x);
        instr_valid <= 1'b1;
        instr       <= x;
        do
            @(posedge clk);
        while (!instr_ready);
        @(negedge clk);
    endtask

    task pace();
        if (burst_left > 0)
            burst_left = burst_left - 1;
        else
        begin
            instr_valid <= 1'b0;
            instr       <= instr_t'({$urandom, $urandom});
            repeat ($urandom_range(1, 12))
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
        end
    endtask

    task issue(instr_t x);
        send(x);
        pace();
    endtask

    task drain();
        instr_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending_results.size() != 0);
    endtask

    initial
    begin
        sb           = new();
        sb.clear_machine();
        rst_n        = 1'b0;
        instr_valid  = 1'b0;
        instr        = '0;
        result_ready = 1'b0;
        idle_cycles  = 0;
        burst_left   = 0;
        stall_style  = 0;
        style_left   = 0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue(make_instr(MODE_OUTPUT, rand_word(), rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_LOOP_BEG, rand_word(), 16'hFFFF, rand_byte(), 1'b1));
        issue(make_instr(MODE_LOOP_END, rand_word(), 16'h0040, rand_byte(), 1'b0));
        issue(make_instr(MODE_ADD, 16'hFFFF, rand_word(), rand_byte(), 1'b1));
        issue(make_instr(MODE_ADD, 16'h0001, rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_SUB, 16'h0001, rand_word(), rand_byte(), 1'b1));
        issue(make_instr(MODE_OUTPUT, rand_word(), rand_word(), rand_byte(), 1'b1));
        issue(make_instr(MODE_LOOP_END, rand_word(), 16'hFFFE, rand_byte(), 1'b0));
        issue(make_instr(MODE_LOOP_BEG, rand_word(), 16'h1234, rand_byte(), 1'b0));
        issue(make_instr(MODE_INPUT, rand_word(), rand_word(), 8'h5A, 1'b1));
        issue(make_instr(MODE_OUTPUT, rand_word(), rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_INPUT, rand_word(), rand_word(), 8'hFF, 1'b0));
        issue(make_instr(MODE_INPUT, rand_word(), rand_word(), 8'h00, 1'b0));
        issue(make_instr(MODE_LEFT, 16'h0001, rand_word(), rand_byte(), 1'b1));
        issue(make_instr(MODE_ADD, 16'h8000, rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_RIGHT, 16'h0001, rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_OUTPUT, rand_word(), rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_RIGHT, 16'hFFFF, rand_word(), rand_byte(), 1'b1));
        issue(make_instr(MODE_OUTPUT, rand_word(), rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_LEFT, 16'hFFFF, rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_SUB, 16'h0000, rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_ADD, 16'h0000, rand_word(), rand_byte(), 1'b1));
        issue(make_instr(MODE_RIGHT, 16'(TAPE_DEPTH), rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_SUB, 16'hFFFF, rand_word(), rand_byte(), 1'b0));
        issue(make_instr(MODE_LOOP_END, rand_word(), rand_word(), rand_byte(), 1'b1));

        // hold the sender until the pipeline is empty
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            issue(random_instr());
            if (i == RANDOM_ITEMS / 2)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("executed %0d instructions: add %0d, sub %0d, right %0d, left %0d,",
                 sb.checked, sb.mode_count[MODE_ADD], sb.mode_count[MODE_SUB],
                 sb.mode_count[MODE_RIGHT], sb.mode_count[MODE_LEFT]);
        $display("loop %0d/%0d with %0d jumps, input %0d (%0d at end of input), output %0d",
                 sb.mode_count[MODE_LOOP_BEG], sb.mode_count[MODE_LOOP_END], sb.jumps,
                 sb.mode_count[MODE_INPUT], sb.eof_reads, sb.bytes_out);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tape_machine_instruction_executor_unit_tb OK");
        else
            $display("tape_machine_instruction_executor_unit_tb NOT OK");
        $finish;
    end

endmodule
